### rtl/core/b64c_pkg.sv
// shared types, constants and alphabet functions of the base64 stream codec
`default_nettype none

package b64c_pkg;

    // configuration port geometry
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // register indexes
    localparam logic [0:0] REG_MODE = 1'b0;

    // mode codes
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // characters and masks
    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SLASH_CHAR = 8'h2F;
    localparam logic [7:0] MASK_2     = 8'h03;
    localparam logic [7:0] MASK_4     = 8'h0F;
    localparam logic [7:0] MASK_6     = 8'h3F;

    // results per item
    localparam int RES_MAX = 4;
    localparam int CNT_W   = 3;

    // one result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
        logic       out_error;
    } t_result;

    // all results of one item
    typedef struct packed {
        logic [CNT_W-1:0]           cnt;
        t_result [RES_MAX-1:0]      res;
    } t_bundle;

    // 6-bit symbol to alphabet character
    function automatic logic [7:0] sym_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (w < 8'd26) begin
            return 8'h41 + w;
        end else if (w < 8'd52) begin
            return 8'h61 + w - 8'd26;
        end else if (w < 8'd62) begin
            return 8'h30 + w - 8'd52;
        end else if (w == 8'd62) begin
            return PLUS_CHAR;
        end else begin
            return SLASH_CHAR;
        end
    endfunction

    // character to {bad, symbol}
    function automatic logic [6:0] char_sym(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'h41;
            return {1'b0, d[5:0]};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'h47;
            return {1'b0, d[5:0]};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d = c + 8'h04;
            return {1'b0, d[5:0]};
        end else if (c == PLUS_CHAR) begin
            return {1'b0, 6'd62};
        end else if (c == SLASH_CHAR) begin
            return {1'b0, 6'd63};
        end else begin
            return {1'b1, 6'd0};
        end
    endfunction

endpackage

`default_nettype wire

### rtl/core/b64c_ifs.sv
// stream channel interfaces of the base64 stream codec
`default_nettype none

interface b64c_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64c_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
    logic       out_error;

    modport source (output valid, output out_byte, output out_valid, output out_last,
                    output out_error, input ready);
    modport sink   (input valid, input out_byte, input out_valid, input out_last,
                    input out_error, output ready);
endinterface

`default_nettype wire

### rtl/core/base64_stream_codec.sv
// Streaming base64 codec (standard alphabet, '=' padding) with an APB mode register.
// Mode 0 encodes data bytes into base64 characters, flushing and padding on the
// word marked last; mode 1 decodes characters into bytes, reporting a bad character,
// misplaced padding or an incomplete final group on the last word of the message,
// which is a bare end marker when the final character completes no byte. Each input
// word is turned into all of its results combinationally and parked in a result
// register that sends one word per cycle while the output is ready; the next input
// word is taken in the cycle the last result of the previous one leaves. Encoding
// thus averages four output words per three input bytes (one to four per byte),
// decoding takes one input word per cycle while the output is not stalled. Writing
// the mode register clears the message state; write it only while the codec is idle.
`default_nettype none

module base64_stream_codec (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    b64c_in_if.sink                          i_in,
    b64c_out_if.source                       o_out,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [b64c_pkg::ADDR_W-1:0] paddr,
    input  wire logic [b64c_pkg::DATA_W-1:0] pwdata,
    output logic      [b64c_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);

    logic r_mode, n_mode;
    logic cfg_wr, mode_sel, clear;
    logic accept, free;
    b64c_pkg::t_bundle bundle;
    b64c_pkg::t_result result;

    // configuration port
    assign pready   = 1'b1;
    assign mode_sel = (paddr[b64c_pkg::ADDR_W-1:2] == b64c_pkg::REG_MODE);
    assign cfg_wr   = psel && penable && pwrite;
    assign clear    = cfg_wr && mode_sel;
    assign n_mode   = clear ? pwdata[0] : r_mode;
    assign prdata   = mode_sel ? {{(b64c_pkg::DATA_W-1){1'b0}}, r_mode} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= b64c_pkg::MODE_ENCODE;
        end else begin
            r_mode <= n_mode;
        end
    end

    // input handshake
    assign i_in.ready = free;
    assign accept     = i_in.valid && free;

    b64c_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mode    (r_mode),
        .i_clear   (clear),
        .i_accept  (accept),
        .i_in_byte (i_in.in_byte),
        .i_in_last (i_in.in_last),
        .o_bundle  (bundle)
    );

    b64c_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_bundle (bundle),
        .i_ready  (o_out.ready),
        .o_valid  (o_out.valid),
        .o_result (result),
        .o_free   (free)
    );

    // output payload
    assign o_out.out_byte  = result.out_byte;
    assign o_out.out_valid = result.out_valid;
    assign o_out.out_last  = result.out_last;
    assign o_out.out_error = result.out_error;

`ifndef SYNTHESIS
    // encoding never reports an error
    a_enc_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (r_mode == b64c_pkg::MODE_ENCODE) |-> !o_out.out_error)
        else $error("error flag raised while encoding");

    // only the final word may be a bare end marker
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.out_last |-> o_out.out_valid)
        else $error("bare end marker before the end of a message");

    // input stalls only while results are pending
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid)
        else $error("input stalled with no result pending");

    // an error only ever rides on the final word
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.out_error |-> o_out.out_last)
        else $error("error flag on a word that is not final");
`endif

endmodule

`default_nettype wire

### rtl/core/b64c_step.sv
// message state and per-word result computation of the base64 stream codec
`default_nettype none

module b64c_step (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_mode,
    input  wire logic             i_clear,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_in_byte,
    input  wire logic             i_in_last,
    output b64c_pkg::t_bundle     o_bundle
);

    logic [1:0] r_phase, n_phase;
    logic [5:0] r_held, n_held;
    logic       r_pad, n_pad;
    logic       r_err, n_err;

    logic [1:0] e_phase, d_phase;
    logic [5:0] e_held, d_held;
    logic       d_pad, d_err;
    logic       d_got;
    logic [7:0] d_data;
    logic [6:0] d_sym;
    logic       d_fin_err;
    b64c_pkg::t_bundle e_bundle, d_bundle, bundle;

    // encoder: symbols, flush and padding
    always_comb begin
        e_bundle = '0;
        e_phase  = r_phase;
        e_held   = r_held;
        unique case (r_phase)
            2'd0: begin
                e_bundle.res[0].out_byte = b64c_pkg::sym_char(i_in_byte[7:2]);
                e_held  = {i_in_byte[1:0], 4'b0000};
                e_phase = 2'd1;
                if (i_in_last) begin
                    e_bundle.res[1].out_byte = b64c_pkg::sym_char(e_held);
                    e_bundle.res[2].out_byte = b64c_pkg::PAD_CHAR;
                    e_bundle.res[3].out_byte = b64c_pkg::PAD_CHAR;
                    e_bundle.cnt = b64c_pkg::CNT_W'(4);
                end else begin
                    e_bundle.cnt = b64c_pkg::CNT_W'(1);
                end
            end
            2'd1: begin
                e_bundle.res[0].out_byte =
                    b64c_pkg::sym_char(r_held | {2'b00, i_in_byte[7:4]});
                e_held  = {i_in_byte[3:0], 2'b00};
                e_phase = 2'd2;
                if (i_in_last) begin
                    e_bundle.res[1].out_byte = b64c_pkg::sym_char(e_held);
                    e_bundle.res[2].out_byte = b64c_pkg::PAD_CHAR;
                    e_bundle.cnt = b64c_pkg::CNT_W'(3);
                end else begin
                    e_bundle.cnt = b64c_pkg::CNT_W'(1);
                end
            end
            2'd2, 2'd3: begin
                e_bundle.res[0].out_byte =
                    b64c_pkg::sym_char(r_held | {4'b0000, i_in_byte[7:6]});
                e_bundle.res[1].out_byte = b64c_pkg::sym_char(i_in_byte[5:0]);
                e_held  = 6'd0;
                e_phase = 2'd0;
                e_bundle.cnt = b64c_pkg::CNT_W'(2);
            end
            default: begin
                e_bundle.cnt = b64c_pkg::CNT_W'(1);
            end
        endcase
        for (int i = 0; i < b64c_pkg::RES_MAX; i++) begin
            e_bundle.res[i].out_valid = 1'b1;
            e_bundle.res[i].out_last  =
                i_in_last && (b64c_pkg::CNT_W'(i) == e_bundle.cnt - b64c_pkg::CNT_W'(1));
        end
    end

    // decoder: character to bits, bytes as they complete, padding rules
    always_comb begin
        d_phase = r_phase;
        d_held  = r_held;
        d_pad   = r_pad;
        d_err   = r_err;
        d_got   = 1'b0;
        d_data  = 8'd0;
        d_sym   = b64c_pkg::char_sym(i_in_byte);
        if (!r_err) begin
            if (i_in_byte == b64c_pkg::PAD_CHAR) begin
                if (r_pad) begin
                    if (r_phase == 2'd3) begin
                        d_phase = 2'd0;
                    end else begin
                        d_err = 1'b1;
                    end
                end else if (r_phase == 2'd2) begin
                    d_pad   = 1'b1;
                    d_phase = 2'd3;
                end else if (r_phase == 2'd3) begin
                    d_pad   = 1'b1;
                    d_phase = 2'd0;
                end else begin
                    d_err = 1'b1;
                end
            end else if (r_pad || d_sym[6]) begin
                d_err = 1'b1;
            end else begin
                unique case (r_phase)
                    2'd0: begin
                        d_held  = d_sym[5:0];
                        d_phase = 2'd1;
                    end
                    2'd1: begin
                        d_data  = {r_held, d_sym[5:4]};
                        d_got   = 1'b1;
                        d_held  = {2'b00, d_sym[3:0]};
                        d_phase = 2'd2;
                    end
                    2'd2: begin
                        d_data  = {r_held[3:0], d_sym[5:2]};
                        d_got   = 1'b1;
                        d_held  = {4'b0000, d_sym[1:0]};
                        d_phase = 2'd3;
                    end
                    default: begin
                        d_data  = {r_held[1:0], d_sym[5:0]};
                        d_got   = 1'b1;
                        d_held  = 6'd0;
                        d_phase = 2'd0;
                    end
                endcase
            end
        end
        // incomplete final group
        d_fin_err = d_err || (d_phase != 2'd0);
        d_bundle = '0;
        d_bundle.res[0].out_byte  = d_data;
        d_bundle.res[0].out_valid = d_got;
        d_bundle.res[0].out_last  = i_in_last;
        d_bundle.res[0].out_error = i_in_last && d_fin_err;
        d_bundle.cnt = (d_got || i_in_last) ? b64c_pkg::CNT_W'(1) : b64c_pkg::CNT_W'(0);
    end

    // mode select and next state
    always_comb begin
        bundle  = (i_mode == b64c_pkg::MODE_DECODE) ? d_bundle : e_bundle;
        n_phase = r_phase;
        n_held  = r_held;
        n_pad   = r_pad;
        n_err   = r_err;
        if (i_clear || (i_accept && i_in_last)) begin
            n_phase = 2'd0;
            n_held  = 6'd0;
            n_pad   = 1'b0;
            n_err   = 1'b0;
        end else if (i_accept) begin
            if (i_mode == b64c_pkg::MODE_DECODE) begin
                n_phase = d_phase;
                n_held  = d_held;
                n_pad   = d_pad;
                n_err   = d_err;
            end else begin
                n_phase = e_phase;
                n_held  = e_held;
            end
        end
    end

    // message state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_held  <= 6'd0;
            r_pad   <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_pad   <= n_pad;
            r_err   <= n_err;
        end
    end

    assign o_bundle = bundle;

endmodule

`default_nettype wire

### rtl/core/b64c_emit.sv
// result register that hands out the words of one item one per cycle while the output is ready
`default_nettype none

module b64c_emit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire b64c_pkg::t_bundle i_bundle,
    input  wire logic              i_ready,
    output logic                   o_valid,
    output b64c_pkg::t_result      o_result,
    output logic                   o_free
);

    b64c_pkg::t_result [b64c_pkg::RES_MAX-1:0] r_res, n_res;
    logic [b64c_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]                 r_idx, n_idx;
    logic                       pop;

    // handshake and space for the next item
    assign o_valid  = (r_cnt != '0);
    assign pop      = o_valid && i_ready;
    assign o_free   = (r_cnt == '0) || (pop && r_cnt == b64c_pkg::CNT_W'(1));
    assign o_result = r_res[r_idx];

    // load a new item or step to the next word
    always_comb begin
        n_res = r_res;
        n_cnt = r_cnt;
        n_idx = r_idx;
        if (i_load) begin
            n_res = i_bundle.res;
            n_cnt = i_bundle.cnt;
            n_idx = 2'd0;
        end else if (pop) begin
            n_cnt = r_cnt - b64c_pkg::CNT_W'(1);
            n_idx = r_idx + 2'd1;
        end
    end

    // payload store
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // word count and read pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            r_idx <= n_idx;
        end
    end

endmodule

`default_nettype wire

### sim/base64_stream_codec_test.sv
// self-checking testbench of the base64 stream codec: encode and decode traffic against a predictor
module base64_stream_codec_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int FAULT_SHOWN   = 10;
    localparam logic [b64c_pkg::ADDR_W-1:0] MODE_ADDR =
        b64c_pkg::ADDR_W'(4 * int'(b64c_pkg::REG_MODE));

    // one pending input word
    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         hold;
    } t_feed;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // configuration port
    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [b64c_pkg::ADDR_W-1:0] paddr   = '0;
    logic [b64c_pkg::DATA_W-1:0] pwdata  = '0;
    logic [b64c_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    // stream channels and the levels driven onto them
    b64c_in_if  feed_if ();
    b64c_out_if word_if ();

    logic       feed_valid = 1'b0;
    logic [7:0] feed_byte  = 8'h00;
    logic       feed_last  = 1'b0;
    logic       word_ready = 1'b0;

    assign feed_if.valid   = feed_valid;
    assign feed_if.in_byte = feed_byte;
    assign feed_if.in_last = feed_last;
    assign word_if.ready   = word_ready;

    base64_stream_codec dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (feed_if),
        .o_out   (word_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // words waiting to be sent, and output words still owed by the codec
    t_feed             feed[$];
    b64c_pkg::t_result due_words[$];
    logic [7:0]        draft[$];
    int                posted;

    // predictor state
    logic       cur_mode  = b64c_pkg::MODE_ENCODE;
    logic [1:0] grp_pos   = 2'd0;
    logic [5:0] carry     = 6'd0;
    bit         pad_taken = 1'b0;
    bit         msg_bad   = 1'b0;

    int faults       = 0;
    int quiet_cycles = 0;
    int send_wait    = 0;
    int recv_wait    = 0;
    bit send_burst   = 1'b0;
    bit recv_burst   = 1'b0;
    bit feed_taken   = 1'b0;
    bit word_taken   = 1'b0;

    function automatic void log_fault(input string msg);
        faults++;
        if (faults <= FAULT_SHOWN) begin
            $display("%s", msg);
        end
    endfunction

    // idle cycles before the next word, with occasional switches into and out of bursts
    function automatic int draw_gap(inout bit burst);
        if ($urandom_range(0, 24) == 0) begin
            burst = !burst;
        end
        return burst ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic logic [7:0] alpha_char(input logic [5:0] v);
        if (v < 6'd26) return 8'h41 + 8'(v);
        if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);
        if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);
        return (v == 6'd62) ? b64c_pkg::PLUS_CHAR : b64c_pkg::SLASH_CHAR;
    endfunction

    // {not in alphabet, symbol value}
    function automatic logic [6:0] alpha_value(input logic [7:0] c);
        for (int v = 0; v < 64; v++) begin
            if (alpha_char(6'(v)) == c) return {1'b0, 6'(v)};
        end
        return 7'b100_0000;
    endfunction

    function automatic b64c_pkg::t_result char_word(input logic [7:0] c);
        return {c, 3'b100};
    endfunction

    function automatic void restart_message();
        grp_pos   = 2'd0;
        carry     = 6'd0;
        pad_taken = 1'b0;
        msg_bad   = 1'b0;
    endfunction

    // work out the output words that one accepted input word causes
    function automatic void translate_item(input logic [7:0] b, input logic lst);
        b64c_pkg::t_result words [b64c_pkg::RES_MAX];
        int         n;
        logic [6:0] code;
        logic [7:0] data;
        bit         got;
        n    = 0;
        got  = 1'b0;
        data = 8'h00;
        if (cur_mode == b64c_pkg::MODE_ENCODE) begin
            // cut the byte into symbols by its place in the group
            case (grp_pos)
                2'd0: begin
                    words[n] = char_word(alpha_char(b[7:2]));
                    n++;
                    carry   = {b[1:0], 4'b0000};
                    grp_pos = 2'd1;
                end
                2'd1: begin
                    words[n] = char_word(alpha_char(carry | {2'b00, b[7:4]}));
                    n++;
                    carry   = {b[3:0], 2'b00};
                    grp_pos = 2'd2;
                end
                default: begin
                    words[n] = char_word(alpha_char(carry | {4'b0000, b[7:6]}));
                    n++;
                    words[n] = char_word(alpha_char(b[5:0]));
                    n++;
                    carry   = 6'd0;
                    grp_pos = 2'd0;
                end
            endcase
            // flush leftover bits and pad out the group
            if (lst) begin
                if (grp_pos != 2'd0) begin
                    words[n] = char_word(alpha_char(carry));
                    n++;
                    words[n] = char_word(b64c_pkg::PAD_CHAR);
                    n++;
                    if (grp_pos == 2'd1) begin
                        words[n] = char_word(b64c_pkg::PAD_CHAR);
                        n++;
                    end
                end
                words[n-1].out_last = 1'b1;
                restart_message();
            end
        end else begin
            // padding may only sit in the 3rd and 4th place of a group
            if (!msg_bad) begin
                if (b == b64c_pkg::PAD_CHAR) begin
                    if (pad_taken) begin
                        if (grp_pos == 2'd3) grp_pos = 2'd0;
                        else msg_bad = 1'b1;
                    end else if (grp_pos == 2'd2) begin
                        pad_taken = 1'b1;
                        grp_pos   = 2'd3;
                    end else if (grp_pos == 2'd3) begin
                        pad_taken = 1'b1;
                        grp_pos   = 2'd0;
                    end else begin
                        msg_bad = 1'b1;
                    end
                end else begin
                    code = alpha_value(b);
                    if (pad_taken || code[6]) begin
                        msg_bad = 1'b1;
                    end else begin
                        case (grp_pos)
                            2'd0: begin
                                carry   = code[5:0];
                                grp_pos = 2'd1;
                            end
                            2'd1: begin
                                data    = {carry, code[5:4]};
                                got     = 1'b1;
                                carry   = {2'b00, code[3:0]};
                                grp_pos = 2'd2;
                            end
                            2'd2: begin
                                data    = {carry[3:0], code[5:2]};
                                got     = 1'b1;
                                carry   = {4'b0000, code[1:0]};
                                grp_pos = 2'd3;
                            end
                            default: begin
                                data    = {carry[1:0], code[5:0]};
                                got     = 1'b1;
                                carry   = 6'd0;
                                grp_pos = 2'd0;
                            end
                        endcase
                    end
                end
            end
            // the final character closes the message, with a bare marker if no byte is due
            if (lst) begin
                if (grp_pos != 2'd0) msg_bad = 1'b1;
                words[n] = got ? {data, 2'b11, msg_bad} : {8'h00, 2'b01, msg_bad};
                n++;
                restart_message();
            end else if (got) begin
                words[n] = char_word(data);
                n++;
            end
        end
        for (int i = 0; i < n; i++) begin
            due_words = {due_words, words[i]};
        end
    endfunction

    // move the drafted message into the send queue
    function automatic void post_draft(input bit hold, input bit closed);
        t_feed it;
        foreach (draft[i]) begin
            it.ch   = draft[i];
            it.last = closed && (i == draft.size() - 1);
            it.hold = hold && (i == 0);
            feed = {feed, it};
        end
        posted += draft.size();
        draft.delete();
    endfunction

    function automatic void draft_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            draft = {draft, 8'(s[i])};
        end
    endfunction

    // one register access over the configuration port; a read is checked against the model
    task automatic mode_reg_access(input bit wr, input logic m);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= MODE_ADDR;
        pwdata  <= b64c_pkg::DATA_W'(m);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (wr) begin
            cur_mode = m;
            restart_message();
        end else if (prdata !== b64c_pkg::DATA_W'(cur_mode)) begin
            log_fault($sformatf("mode register read: expected %0h, got %h", cur_mode, prdata));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_mode(input logic m);
        mode_reg_access(1'b1, m);
        mode_reg_access(1'b0, m);
    endtask

    // all sent, all results in, then a settling wait for words that cause none
    task automatic wait_idle();
        @(posedge i_clk);
        while (feed.size() != 0 || feed_valid || due_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // input driver: next word once the slot is free and the gap has run out
    always @(negedge i_clk) begin : feed_drive
        t_feed item;
        if (i_rst_n && (!feed_valid || feed_taken)) begin
            if (send_wait > 0) begin
                send_wait--;
                feed_valid <= 1'b0;
            end else if (feed.size() > 0 && !(feed[0].hold && due_words.size() > 0)) begin
                item = feed.pop_front();
                feed_byte  <= item.ch;
                feed_last  <= item.last;
                feed_valid <= 1'b1;
                send_wait  = draw_gap(send_burst);
            end else begin
                feed_valid <= 1'b0;
            end
        end
    end

    // output side: stall for a drawn number of cycles after each word
    always @(negedge i_clk) begin : word_drain
        if (i_rst_n) begin
            if (word_taken) begin
                recv_wait = draw_gap(recv_burst);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                word_ready <= 1'b0;
            end else begin
                word_ready <= 1'b1;
            end
        end
    end

    // monitor: predict on accepted input words, check accepted output words
    always @(posedge i_clk) begin : watch
        b64c_pkg::t_result seen;
        b64c_pkg::t_result want;
        feed_taken <= i_rst_n && feed_if.valid && feed_if.ready;
        word_taken <= i_rst_n && word_if.valid && word_if.ready;
        if (i_rst_n && feed_if.valid && feed_if.ready) begin
            translate_item(feed_if.in_byte, feed_if.in_last);
        end
        if (i_rst_n && word_if.valid && word_if.ready) begin
            seen = {word_if.out_byte, word_if.out_valid, word_if.out_last, word_if.out_error};
            if (due_words.size() == 0) begin
                log_fault($sformatf("unexpected word: byte %h valid %b last %b error %b",
                    seen.out_byte, seen.out_valid, seen.out_last, seen.out_error));
            end else begin
                want = due_words.pop_front();
                if (seen.out_byte !== want.out_byte || seen.out_valid !== want.out_valid ||
                    seen.out_last !== want.out_last || seen.out_error !== want.out_error) begin
                    log_fault({
                        $sformatf("word mismatch: expected byte %h valid %b last %b error %b",
                            want.out_byte, want.out_valid, want.out_last, want.out_error),
                        $sformatf(", got byte %h valid %b last %b error %b",
                            seen.out_byte, seen.out_valid, seen.out_last, seen.out_error)});
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((feed_if.valid && feed_if.ready) || (word_if.valid && word_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int len;
        int groups;
        int tail;
        int kind;
        int drop;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset value of the mode register, then encode tails of one, two and three bytes
        mode_reg_access(1'b0, b64c_pkg::MODE_ENCODE);
        draft = '{8'h00};
        post_draft(1'b0, 1'b1);
        draft = '{8'hFF, 8'hFF};
        post_draft(1'b0, 1'b1);
        draft = '{8'hFB, 8'hFF, 8'hBF};
        post_draft(1'b0, 1'b1);
        wait_idle();

        // decode: valid groups, double and single padding, misplaced padding, bad characters
        set_mode(b64c_pkg::MODE_DECODE);
        draft_text("+/9aTWE==");
        post_draft(1'b0, 1'b1);
        draft_text("TQ==");
        post_draft(1'b0, 1'b1);
        draft_text("TW=x");
        post_draft(1'b0, 1'b1);
        draft_text("=");
        post_draft(1'b0, 1'b1);
        draft_text("TQ=");
        post_draft(1'b0, 1'b1);
        draft = '{8'hFF};
        post_draft(1'b0, 1'b1);
        // half a group left open, to be dropped by the next mode write
        draft_text("TW");
        post_draft(1'b0, 1'b0);
        wait_idle();

        // random encode messages, mostly short
        set_mode(b64c_pkg::MODE_ENCODE);
        posted = 0;
        while (posted < 110) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
            repeat (len) draft = {draft, 8'($urandom_range(0, 255))};
            post_draft(posted == 0 || $urandom_range(0, 29) == 0, 1'b1);
        end
        draft = '{8'h5A};
        post_draft(1'b0, 1'b0);
        wait_idle();

        // random decode: mostly well-formed text, some corrupted, cut short or pure noise
        set_mode(b64c_pkg::MODE_DECODE);
        posted = 0;
        while (posted < 140) begin
            kind = $urandom_range(0, 9);
            if (kind == 9) begin
                len = $urandom_range(1, 6);
                repeat (len) draft = {draft, 8'($urandom_range(0, 255))};
            end else begin
                groups = $urandom_range(0, 3);
                tail   = $urandom_range(0, 2);
                if (groups == 0 && tail == 0) groups = 1;
                repeat (4 * groups) draft = {draft, alpha_char(6'($urandom_range(0, 63)))};
                if (tail != 0) begin
                    repeat (tail + 1) draft = {draft, alpha_char(6'($urandom_range(0, 63)))};
                    repeat (3 - tail) draft = {draft, b64c_pkg::PAD_CHAR};
                end
                if (kind == 7) begin
                    draft[$urandom_range(0, draft.size() - 1)] =
                        $urandom_range(0, 1) ? b64c_pkg::PAD_CHAR : 8'($urandom_range(0, 255));
                end else if (kind == 8 && draft.size() > 1) begin
                    drop = $urandom_range(1, (draft.size() > 4) ? 3 : draft.size() - 1);
                    repeat (drop) void'(draft.pop_back());
                end
            end
            post_draft($urandom_range(0, 29) == 0, 1'b1);
        end
        draft_text("T");
        post_draft(1'b0, 1'b0);
        wait_idle();

        // rewriting the same mode still clears the open group
        set_mode(b64c_pkg::MODE_DECODE);
        draft_text("TWFu");
        post_draft(1'b1, 1'b1);
        wait_idle();

        if (faults == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
